[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge out of reset.
`define BZG_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define BZG_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define BZG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/bzg_pkg.sv]
// Shared types and constants of the bounded zero-effort-miss guidance block.
`timescale 1ns / 1ps
`default_nettype none

package bzg_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int AXES          = 3;
    localparam int MAG_W         = 31;
    localparam int IN_W          = 7 * DATA_W;
    localparam int OUT_W         = AXES * DATA_W;
    localparam int CFG_IDX_W     = 8;
    localparam int QUEUE_DEPTH   = 4;
    localparam int ROOT_W        = 32;
    localparam int QUOT_W        = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRUST = 8'd0,
        REG_GRAV_X = 8'd1,
        REG_GRAV_Y = 8'd2,
        REG_GRAV_Z = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [AXES-1:0][MAG_W-1:0] mag;
        logic [AXES-1:0]            neg;
        logic                       zero;
    } miss_item_t;

endpackage

`default_nettype wire

[rtl/bzg_front.sv]
// Front end: forms the miss vector, its signs and its normalised magnitudes.
`timescale 1ns / 1ps
`default_nettype none

module bzg_front
    import bzg_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [IN_W-1:0] in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output miss_item_t      out_item
);

    localparam int ZEM_W = 66 - FRAC_BITS;
    localparam int MAGF_W = 65 - FRAC_BITS;
    localparam int SH_W = $clog2(MAGF_W + 1);
    localparam int STAGES = 6;

    logic [STAGES-1:0] v_reg;
    logic              adv;

    logic [AXES-1:0][63:0]           prod_reg;
    logic [AXES-1:0][DATA_W-1:0]     ra_reg;
    logic [AXES-1:0]                 vneg_reg;
    logic [AXES-1:0][64:0]           sp_reg;
    logic [AXES-1:0][DATA_W-1:0]     rb_reg;
    logic [AXES-1:0][ZEM_W-1:0]      zem_reg;
    logic [AXES-1:0][MAGF_W-1:0]     magd_reg;
    logic [AXES-1:0]                 negd_reg;
    logic [AXES-1:0][MAGF_W-1:0]     mage_reg;
    logic [AXES-1:0]                 nege_reg;
    logic                            zero_reg;
    miss_item_t                      item_reg;

    logic [AXES-1:0][DATA_W-1:0]     vmag;
    logic [AXES-1:0][ZEM_W-1:0]      zem_next;
    logic [MAGF_W-1:0]               or_all;
    logic [SH_W-1:0]                 len;
    logic [SH_W-1:0]                 sh_next;

    assign adv       = !v_reg[STAGES-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = v_reg[STAGES-1];
    assign out_item  = item_reg;

    always_comb
    begin
        logic signed [64:0] shifted;
        for (int i = 0; i < AXES; i++)
        begin
            vmag[i] = in_data[DATA_W*(3+i) + DATA_W-1]
                    ? DATA_W'(-in_data[DATA_W*(3+i) +: DATA_W])
                    : in_data[DATA_W*(3+i) +: DATA_W];
            shifted = $signed(sp_reg[i]) >>> FRAC_BITS;
            zem_next[i] = ZEM_W'($signed(shifted[ZEM_W-1:0])
                        + $signed({{(ZEM_W-DATA_W){rb_reg[i][DATA_W-1]}}, rb_reg[i]}));
        end
    end

    always_comb
    begin
        or_all = mage_reg[0] | mage_reg[1] | mage_reg[2];
        len = '0;
        for (int b = 0; b < MAGF_W; b++)
        begin
            if (or_all[b])
            begin
                len = SH_W'(b + 1);
            end
        end
        sh_next = (len > SH_W'(MAG_W)) ? SH_W'(len - SH_W'(MAG_W)) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                prod_reg[i] <= 64'(in_data[DATA_W*6 +: DATA_W]) * 64'(vmag[i]);
                ra_reg[i]   <= in_data[DATA_W*i +: DATA_W];
                vneg_reg[i] <= in_data[DATA_W*(3+i) + DATA_W-1];
                sp_reg[i]   <= vneg_reg[i] ? 65'(-{1'b0, prod_reg[i]}) : {1'b0, prod_reg[i]};
                rb_reg[i]   <= ra_reg[i];
                zem_reg[i]  <= zem_next[i];
                negd_reg[i] <= zem_reg[i][ZEM_W-1];
                magd_reg[i] <= zem_reg[i][ZEM_W-1] ? MAGF_W'(-zem_reg[i])
                                                   : zem_reg[i][MAGF_W-1:0];
                mage_reg[i] <= magd_reg[i];
                nege_reg[i] <= negd_reg[i];
                item_reg.mag[i] <= MAG_W'(mage_reg[i] >> sh_next);
                item_reg.neg[i] <= nege_reg[i];
            end
            zero_reg <= (magd_reg[0] | magd_reg[1] | magd_reg[2]) == '0;
            item_reg.zero <= zero_reg;
        end
    end

endmodule

`default_nettype wire

[rtl/bzg_queue.sv]
// Short queue that decouples the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none

module bzg_queue
    import bzg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  miss_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output miss_item_t out_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    miss_item_t           slot_reg [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0]     wr_reg;
    logic [PTR_W-1:0]     rd_reg;
    logic [PTR_W:0]       count_reg;
    logic                 push;
    logic                 pop;

    assign in_ready  = count_reg != (PTR_W+1)'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = slot_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

[rtl/bzg_back.sv]
// Back end: pipelined square root, per-axis division and gravity addition.
`timescale 1ns / 1ps
`default_nettype none

module bzg_back
    import bzg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  miss_item_t             in_item,
    input  logic [DATA_W-1:0]      thrust_bound,
    input  logic [DATA_W-1:0]      gravity_x,
    input  logic [DATA_W-1:0]      gravity_y,
    input  logic [DATA_W-1:0]      gravity_z,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_W-1:0]       out_data,
    output logic                   out_zero
);

    localparam int SQ_POS  = 2;
    localparam int DIV_POS = SQ_POS + ROOT_W + 1;
    localparam int LAST    = DIV_POS + QUOT_W + 1;

    logic [LAST:0]                 v_reg;
    logic                          adv;
    miss_item_t                    it_reg [0:LAST-1];

    logic [AXES-1:0][2*MAG_W-1:0]  sq_reg;

    logic [63:0]                   sx_reg    [0:ROOT_W];
    logic [33:0]                   srem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0]             sroot_reg [0:ROOT_W];

    logic [ROOT_W-1:0]             dnorm_reg [0:QUOT_W];
    logic [AXES-1:0][QUOT_W-1:0]   drem_reg  [0:QUOT_W];
    logic [AXES-1:0][QUOT_W-1:0]   dlow_reg  [0:QUOT_W];

    logic [AXES-1:0][DATA_W-1:0]   grav;
    logic [OUT_W-1:0]              data_reg;
    logic                          zero_reg;

    assign adv       = !v_reg[LAST] || out_ready;
    assign in_ready  = adv;
    assign out_valid = v_reg[LAST];
    assign out_data  = data_reg;
    assign out_zero  = zero_reg;
    assign grav      = {gravity_z, gravity_y, gravity_x};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[LAST-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it_reg[0] <= in_item;
            for (int p = 1; p < LAST; p++)
            begin
                it_reg[p] <= it_reg[p-1];
            end
            for (int i = 0; i < AXES; i++)
            begin
                sq_reg[i] <= (2*MAG_W)'(it_reg[0].mag[i]) * (2*MAG_W)'(it_reg[0].mag[i]);
            end
            sx_reg[0]    <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
            srem_reg[0]  <= '0;
            sroot_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        logic [34:0] t;
        logic [34:0] trial;
        logic        ge;

        assign t     = {srem_reg[k][32:0], sx_reg[k][63:62]};
        assign trial = {1'b0, sroot_reg[k], 2'b01};
        assign ge    = t >= trial;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sx_reg[k+1]    <= {sx_reg[k][61:0], 2'b00};
                srem_reg[k+1]  <= ge ? 34'(t - trial) : t[33:0];
                sroot_reg[k+1] <= {sroot_reg[k][ROOT_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic [62:0] prod;
        if (adv)
        begin
            dnorm_reg[0] <= sroot_reg[ROOT_W];
            for (int i = 0; i < AXES; i++)
            begin
                prod = 63'(thrust_bound) * 63'(it_reg[DIV_POS-1].mag[i]);
                drem_reg[0][i] <= {1'b0, prod[62:32]};
                dlow_reg[0][i] <= prod[31:0];
            end
        end
    end

    for (genvar j = 0; j < QUOT_W; j++)
    begin : g_div
        for (genvar i = 0; i < AXES; i++)
        begin : g_axis
            logic [QUOT_W:0] t;
            logic            ge;

            assign t  = {drem_reg[j][i], dlow_reg[j][i][QUOT_W-1]};
            assign ge = t >= {1'b0, dnorm_reg[j]};

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    drem_reg[j+1][i] <= ge ? QUOT_W'(t - {1'b0, dnorm_reg[j]})
                                           : t[QUOT_W-1:0];
                    dlow_reg[j+1][i] <= {dlow_reg[j][i][QUOT_W-2:0], ge};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dnorm_reg[j+1] <= dnorm_reg[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [DATA_W+1:0] term;
        logic signed [DATA_W+1:0] total;
        if (adv)
        begin
            zero_reg <= it_reg[LAST-1].zero;
            for (int i = 0; i < AXES; i++)
            begin
                term = it_reg[LAST-1].neg[i] ? -$signed({2'b00, dlow_reg[QUOT_W][i]})
                                             : $signed({2'b00, dlow_reg[QUOT_W][i]});
                total = term + $signed({{2{grav[i][DATA_W-1]}}, grav[i]});
                if (it_reg[LAST-1].zero)
                begin
                    data_reg[DATA_W*i +: DATA_W] <= grav[i];
                end
                else if (total > $signed({3'b000, {(DATA_W-1){1'b1}}}))
                begin
                    data_reg[DATA_W*i +: DATA_W] <= {1'b0, {(DATA_W-1){1'b1}}};
                end
                else if (total < $signed({3'b111, {(DATA_W-1){1'b0}}}))
                begin
                    data_reg[DATA_W*i +: DATA_W] <= {1'b1, {(DATA_W-1){1'b0}}};
                end
                else
                begin
                    data_reg[DATA_W*i +: DATA_W] <= total[DATA_W-1:0];
                end
            end
        end
    end

endmodule

`default_nettype wire

[rtl/bounded_zem_guidance_command.sv]
// Top level of the bounded zero-effort-miss guidance command block.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata: pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, time_to_go
//  m_axis    out        tdata: cmd_x, cmd_y, cmd_z; tuser: zero_miss
//  cfg       in         cfg_index, cfg_data (always ready)
//
//  One request is taken every cycle unless the front end is stalled by a full queue.
//  The back end holds a 32-step square root pipeline and a 32-step divider pipeline.
//  Reset clears all control state and loads the default thrust bound and gravity.
//  A stalled output stalls the back end; the queue then lets the front end run on until it is full.
`timescale 1ns / 1ps
`default_nettype none

module bounded_zem_guidance_command
    import bzg_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, time_to_go
    input  logic [IN_W-1:0]      s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // cmd_x, cmd_y, cmd_z
    output logic [OUT_W-1:0]     m_axis_tdata,
    // zero_miss
    output logic                 m_axis_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    localparam longint GZ_MAG = (981 * (64'd1 << FRAC_BITS) + 50) / 100;
    localparam logic [DATA_W-1:0] THRUST_RST = DATA_W'(64'd20 << FRAC_BITS);
    localparam logic [DATA_W-1:0] GRAV_Z_RST = DATA_W'(-GZ_MAG);

    logic [DATA_W-1:0] thrust_reg;
    logic [DATA_W-1:0] grav_x_reg;
    logic [DATA_W-1:0] grav_y_reg;
    logic [DATA_W-1:0] grav_z_reg;

    miss_item_t front_item;
    logic       front_valid;
    logic       front_ready;
    miss_item_t back_item;
    logic       back_valid;
    logic       back_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thrust_reg <= THRUST_RST;
            grav_x_reg <= '0;
            grav_y_reg <= '0;
            grav_z_reg <= GRAV_Z_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_THRUST: thrust_reg <= cfg_data;
                REG_GRAV_X: grav_x_reg <= cfg_data;
                REG_GRAV_Y: grav_y_reg <= cfg_data;
                REG_GRAV_Z: grav_z_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    bzg_front #(.FRAC_BITS(FRAC_BITS)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_item  (front_item)
    );

    bzg_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_item  (back_item)
    );

    bzg_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (back_valid),
        .in_ready     (back_ready),
        .in_item      (back_item),
        .thrust_bound (thrust_reg),
        .gravity_x    (grav_x_reg),
        .gravity_y    (grav_y_reg),
        .gravity_z    (grav_z_reg),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (m_axis_tdata),
        .out_zero     (m_axis_tuser)
    );

endmodule

`default_nettype wire

[rtl/bzg_checker.sv]
// Port-level checker for the guidance block and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bzg_checker
    import bzg_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [IN_W-1:0]      s_axis_tdata,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [OUT_W-1:0]     m_axis_tdata,
    input logic                 m_axis_tuser,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [DATA_W-1:0]    cfg_data
);

    // Configuration writes are never refused.
    `BZG_ASSERT_ALWAYS(a_cfg_ready, cfg_ready)

    // Output readiness always drains enough of the queue to take a request in the cycle after.
    `BZG_ASSERT_IMPLIES(a_in_ready, $past(m_axis_tready), s_axis_tready)

    // A stalled result holds its value.
    `BZG_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind bounded_zem_guidance_command bzg_checker u_chk (.*);

`default_nettype wire

[bench/bounded_zem_guidance_command_test.sv]
// Self-checking testbench for the bounded zero-effort-miss guidance command block.
`timescale 1ns / 1ps

module bounded_zem_guidance_command_test;
    import bzg_pkg::*;

    localparam int PERIOD_NS = 8;
    localparam int LATENCY = 75;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1230;
    localparam int QUIET_ITEMS = 150;
    localparam int LONG_STALL = 300;

    typedef struct {
        logic signed [31:0] pos [3];
        logic signed [31:0] vel [3];
        logic        [31:0] tgo;
    } guidance_req_t;

    typedef struct {
        logic signed [31:0] cmd [3];
        logic               zero_miss;
    } guidance_cmd_t;

    typedef struct {
        guidance_req_t req;
        bit            typed;
        guidance_cmd_t cmd;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;
    logic m_axis_tuser;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0] cfg_data;

    logic [31:0] thrust_bound;
    logic signed [31:0] gravity [3];

    guidance_cmd_t expected_cmds [$];
    int errors = 0;
    int cycles = 0;
    bit out_idle_enable = 1;
    bit long_stall = 0;

    bounded_zem_guidance_command uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #(PERIOD_NS / 2) clk = ~clk;
    end

    function automatic guidance_cmd_t guidance_command(guidance_req_t req);
        guidance_cmd_t res;
        logic [63:0] mag [3];
        bit neg [3];
        logic [63:0] vm, m, maxm, sum, norm, op, bitv, d;
        logic signed [63:0] q, zem, term;
        int s;
        maxm = 0;
        sum = 0;
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            vm = (req.vel[i] < 0) ? 64'(-64'(req.vel[i])) : 64'(req.vel[i]);
            m = 64'(req.tgo) * vm;
            if (req.vel[i] < 0)
                q = -$signed((m + 64'hFFFF) >> 16);
            else
                q = $signed(m >> 16);
            zem = 64'(req.pos[i]) + q;
            neg[i] = zem < 0;
            mag[i] = neg[i] ? -zem : zem;
            if (mag[i] > maxm)
                maxm = mag[i];
        end
        while ((maxm >> s) >= 64'h8000_0000)
            s++;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = mag[i] >> s;
            sum += mag[i] * mag[i];
        end
        if (sum == 0)
        begin
            for (int i = 0; i < 3; i++)
                res.cmd[i] = gravity[i];
            res.zero_miss = 1;
            return res;
        end
        op = sum;
        norm = 0;
        bitv = 64'd1 << 62;
        while (bitv > op)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (op >= norm + bitv)
            begin
                op -= norm + bitv;
                norm = (norm >> 1) + bitv;
            end
            else
                norm >>= 1;
            bitv >>= 2;
        end
        for (int i = 0; i < 3; i++)
        begin
            d = (64'(thrust_bound) * mag[i]) / norm;
            term = (neg[i] ? -$signed(d) : $signed(d)) + 64'(gravity[i]);
            if (term > 64'sd2147483647)
                term = 64'sd2147483647;
            if (term < -64'sd2147483648)
                term = -64'sd2147483648;
            res.cmd[i] = term[31:0];
        end
        res.zero_miss = 0;
        return res;
    endfunction

    function automatic guidance_req_t random_request();
        guidance_req_t req;
        int shape;
        for (int i = 0; i < 3; i++)
        begin
            shape = $urandom_range(0, 9);
            req.pos[i] = shape == 0 ? 32'sh8000_0000 : shape == 1 ? 32'sh7FFF_FFFF :
                         shape < 5 ? $signed(32'($urandom_range(0, 65535)) - 32'sd32768) :
                         $urandom;
            shape = $urandom_range(0, 9);
            req.vel[i] = shape == 0 ? 32'sh8000_0000 : shape == 1 ? 32'sh7FFF_FFFF :
                         shape < 5 ? $signed(32'($urandom_range(0, 65535)) - 32'sd32768) :
                         $urandom;
        end
        shape = $urandom_range(0, 9);
        req.tgo = shape == 0 ? 32'd0 : shape == 1 ? 32'hFFFF_FFFF :
                  shape < 6 ? 32'($urandom_range(0, 1 << 20)) : $urandom;
        if ($urandom_range(0, 19) == 0)
        begin
            req.tgo = 32'h1_0000;
            for (int i = 0; i < 3; i++)
                req.pos[i] = -req.vel[i];
        end
        return req;
    endfunction

    task automatic write_register(cfg_reg_t idx, logic [31:0] value);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 0;
        case (idx)
            REG_THRUST: thrust_bound = value;
            REG_GRAV_X: gravity[0] = value;
            REG_GRAV_Y: gravity[1] = value;
            REG_GRAV_Z: gravity[2] = value;
            default: ;
        endcase
    endtask

    task automatic load_settings(logic [31:0] thrust, logic [31:0] gx, logic [31:0] gy,
                                 logic [31:0] gz);
        while (expected_cmds.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
        write_register(REG_THRUST, thrust);
        write_register(REG_GRAV_X, gx);
        write_register(REG_GRAV_Y, gy);
        write_register(REG_GRAV_Z, gz);
    endtask

    task automatic send_request(guidance_req_t req, bit idle);
        if (idle && $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 12)) @(negedge clk);
        s_axis_tdata = {req.tgo, req.vel[2], req.vel[1], req.vel[0],
                        req.pos[2], req.pos[1], req.pos[0]};
        s_axis_tvalid = 1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_cmds.push_back(guidance_command(req));
        @(negedge clk);
        s_axis_tvalid = 0;
    endtask

    initial
    begin
        int burst;
        m_axis_tready = 0;
        @(negedge clk);
        forever
        begin
            if (long_stall)
            begin
                m_axis_tready <= 0;
                repeat (LONG_STALL) @(negedge clk);
                long_stall = 0;
            end
            else if (out_idle_enable && $urandom_range(0, 9) == 0)
            begin
                burst = $urandom_range(1, 12);
                m_axis_tready <= 0;
                repeat (burst) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= 1;
                @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        guidance_cmd_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_cmds.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected: %h %b", $time, m_axis_tdata,
                         m_axis_tuser);
            end
            else
            begin
                want = expected_cmds.pop_front();
                for (int i = 0; i < 3; i++)
                    if (m_axis_tdata[32*i +: 32] !== want.cmd[i])
                    begin
                        errors++;
                        $display("%0t: cmd[%0d] expected %h actual %h", $time, i,
                                 want.cmd[i], m_axis_tdata[32*i +: 32]);
                    end
                if (m_axis_tuser !== want.zero_miss)
                begin
                    errors++;
                    $display("%0t: zero_miss expected %b actual %b", $time,
                             want.zero_miss, m_axis_tuser);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows [$];
        stim_row_t row;
        guidance_req_t req;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        cfg_valid = 0;
        cfg_index = REG_THRUST;
        cfg_data = '0;
        thrust_bound = 32'd1310720;
        gravity[0] = 0;
        gravity[1] = 0;
        gravity[2] = -32'sd642908;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Zero miss after reset: default gravity alone.
        row = '{default: '0};
        row.typed = 1;
        row.cmd.cmd = '{0, 0, -32'sd642908};
        row.cmd.zero_miss = 1;
        rows.push_back(row);
        // Position along +x only: full thrust on x plus gravity.
        row = '{default: '0};
        row.req.pos[0] = 32'sd65536;
        row.typed = 1;
        row.cmd.cmd = '{32'sd1310720, 0, -32'sd642908};
        rows.push_back(row);
        // Velocity cancels position exactly at one second.
        row = '{default: '0};
        row.req.pos = '{32'sd65536, -32'sd131072, 32'sd5};
        row.req.vel = '{-32'sd65536, 32'sd131072, -32'sd5};
        row.req.tgo = 32'h1_0000;
        row.typed = 1;
        row.cmd.cmd = '{0, 0, -32'sd642908};
        row.cmd.zero_miss = 1;
        rows.push_back(row);
        // Field extremes and small values, checked against the predictor.
        row = '{default: '0};
        row.req.pos = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
        row.req.vel = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF};
        row.req.tgo = 32'hFFFF_FFFF;
        rows.push_back(row);
        row.req.pos = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        row.req.vel = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        rows.push_back(row);
        row.req.vel = '{-32'sd1, -32'sd1, -32'sd1};
        row.req.pos = '{0, 0, 0};
        row.req.tgo = 32'd1;
        rows.push_back(row);
        row.req.vel = '{0, 0, 0};
        row.req.pos = '{-32'sd1, 32'sd1, 0};
        rows.push_back(row);
        row.req.pos = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
        row.req.tgo = 0;
        rows.push_back(row);

        foreach (rows[k])
        begin
            if (rows[k].typed)
            begin
                guidance_cmd_t p;
                bit same;
                p = guidance_command(rows[k].req);
                same = p.zero_miss === rows[k].cmd.zero_miss;
                for (int i = 0; i < 3; i++)
                    if (p.cmd[i] !== rows[k].cmd.cmd[i])
                        same = 0;
                if (!same)
                begin
                    errors++;
                    $display("%0t: table row %0d expected %p predicted %p", $time, k,
                             rows[k].cmd, p);
                end
            end
            send_request(rows[k].req, 0);
        end

        load_settings(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        for (int k = 0; k < 6; k++)
            send_request(rows[k + 2].req, 0);
        load_settings(32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        for (int k = 0; k < 6; k++)
            send_request(rows[k + 2].req, 0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 250 == 0)
                load_settings($urandom, $urandom, $urandom, $urandom);
            if (n == 400)
                long_stall = 1;
            if (n == 700)
                while (expected_cmds.size() != 0)
                    @(negedge clk);
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                out_idle_enable = 0;
            req = random_request();
            send_request(req, n < RANDOM_ITEMS - QUIET_ITEMS);
        end

        while (expected_cmds.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/bzg_pkg.sv
rtl/bzg_front.sv
rtl/bzg_queue.sv
rtl/bzg_back.sv
rtl/bounded_zem_guidance_command.sv
rtl/bzg_checker.sv
bench/bounded_zem_guidance_command_test.sv
